// ===== rtl/assert_macros.svh =====
// Assertion macros for the port-level checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition in this cycle implies consequence in the same cycle.
`define ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Condition in this cycle implies consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/jnl_pkg.sv =====
// Types, constants and character classes of the JSON number lexer.
`timescale 1ns / 1ps

package jnl_pkg;

	localparam int VALUE_BITS  = 32;
	localparam int LENGTH_BITS = 16;
	localparam int STATUS_BITS = 3;
	localparam int PROD_BITS   = VALUE_BITS + 4;

	// Character codes
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_ONE    = 8'h31;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_EXP_UC = 8'h45;
	localparam logic [7:0] CH_EXP_LC = 8'h65;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	typedef enum logic [3:0] {
		GS_START       = 4'd0,
		GS_MINUS       = 4'd1,
		GS_ZERO        = 4'd2,
		GS_INT_FIRST   = 4'd3,
		GS_INT_MORE    = 4'd4,
		GS_FRAC_START  = 4'd5,
		GS_FRAC_DIGITS = 4'd6,
		GS_EXP_START   = 4'd7,
		GS_EXP_SIGN    = 4'd8,
		GS_EXP_DIGITS  = 4'd9
	} gstate_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_BUSY = 3'd0,
		ST_INT  = 3'd1,
		ST_FRAC = 3'd2,
		ST_EXP  = 3'd3,
		ST_ERR  = 3'd4
	} status_t;

	typedef struct packed {
		logic [7:0] character;
		logic       at_end;
	} in_word_t;

	typedef struct packed {
		logic [STATUS_BITS-1:0]        status;
		logic signed [VALUE_BITS-1:0]  int_value;
		logic                          overflow;
		logic [LENGTH_BITS-1:0]        consumed_length;
	} out_word_t;

	typedef struct packed {
		gstate_t                gs;
		logic [VALUE_BITS-1:0]  magnitude;
		logic                   is_negative;
		logic                   saturated;
		logic                   seen_fraction;
		logic                   seen_exponent;
		logic [LENGTH_BITS-1:0] char_count;
	} lex_state_t;

	localparam lex_state_t STATE_RESET = '{
		gs:            GS_START,
		magnitude:     '0,
		is_negative:   1'b0,
		saturated:     1'b0,
		seen_fraction: 1'b0,
		seen_exponent: 1'b0,
		char_count:    '0
	};

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_nz_digit(input logic [7:0] c);
		return (c >= CH_ONE) && (c <= CH_NINE);
	endfunction

	function automatic logic is_exp_mark(input logic [7:0] c);
		return (c == CH_EXP_UC) || (c == CH_EXP_LC);
	endfunction

	function automatic logic is_delim(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_LF) || (c == CH_CR) || (c == CH_TAB) ||
			(c == CH_COMMA) || (c == CH_RBRACK) || (c == CH_RBRACE);
	endfunction

endpackage

// ===== rtl/json_number_lexer_top.sv =====
// JSON number lexer: one character word in, one result word out.
// The result word of an accepted character word is registered and valid in the next cycle.
// Throughput: one character word per cycle while result_ready is high, set by the single result register,
// which reloads in the cycle it is taken.
// Reset: grammar state returns to expecting the first character, the result
// register is emptied; state also re-arms after every finished or failed number.
`timescale 1ns / 1ps

module json_number_lexer_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               char_valid,
	output logic               char_ready,
	input  jnl_pkg::in_word_t  char_word,
	output logic               result_valid,
	input  logic               result_ready,
	output jnl_pkg::out_word_t result_word
);
	import jnl_pkg::*;

	lex_state_t            state_q;
	lex_state_t            state_nxt;
	status_t               status;
	logic                  result_valid_q;
	out_word_t             result_q;
	logic                  accept;
	logic [VALUE_BITS-1:0] signed_mag;

	jnl_step u_step (
		.cur    (state_q),
		.word   (char_word),
		.nxt    (state_nxt),
		.status (status)
	);

	// Take a new word whenever the result register is empty or being drained
	assign char_ready   = !result_valid_q || result_ready;
	assign accept       = char_valid && char_ready;
	assign result_valid = result_valid_q;
	assign result_word  = result_q;

	assign signed_mag = state_nxt.is_negative ? (VALUE_BITS'(0) - state_nxt.magnitude)
		: state_nxt.magnitude;

	// Advance lexer state; re-arm once a number finishes or fails
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (accept) begin
			state_q <= (status == ST_BUSY) ? state_nxt : STATE_RESET;
		end
	end

	// Hold result valid until the word is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (accept) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	// Load the result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			result_q.status          <= status;
			result_q.int_value       <= signed_mag;
			result_q.overflow        <= state_nxt.saturated;
			result_q.consumed_length <= state_nxt.char_count;
		end
	end

endmodule

// ===== rtl/jnl_step.sv =====
// Grammar step: next lexer state and status for one character word.
`timescale 1ns / 1ps

module jnl_step (
	input  jnl_pkg::lex_state_t cur,
	input  jnl_pkg::in_word_t   word,
	output jnl_pkg::lex_state_t nxt,
	output jnl_pkg::status_t    status
);
	import jnl_pkg::*;

	logic [7:0]            c;
	logic                  take;
	logic                  add_dig;
	logic                  set_neg;
	logic                  set_frac;
	logic                  set_exp;
	gstate_t               gs_next;
	logic                  accepting;
	status_t               kind;
	logic [3:0]            digit;
	logic [PROD_BITS-1:0]  mag_ext;
	logic [PROD_BITS-1:0]  limit;
	logic [PROD_BITS-1:0]  prod;
	logic                  over;

	assign c = word.character;

	// Next grammar state and the actions of this character
	always_comb begin
		take     = 1'b0;
		add_dig  = 1'b0;
		set_neg  = 1'b0;
		set_frac = 1'b0;
		set_exp  = 1'b0;
		gs_next  = cur.gs;
		if (!word.at_end) begin
			unique case (cur.gs)
				GS_START, GS_MINUS: begin
					if (is_nz_digit(c)) begin
						add_dig = 1'b1;
						gs_next = GS_INT_FIRST;
						take    = 1'b1;
					end else if (c == CH_ZERO) begin
						gs_next = GS_ZERO;
						take    = 1'b1;
					end else if (c == CH_MINUS && cur.gs == GS_START) begin
						set_neg = 1'b1;
						gs_next = GS_MINUS;
						take    = 1'b1;
					end
				end
				GS_ZERO, GS_INT_FIRST, GS_INT_MORE: begin
					if (is_digit(c) && cur.gs != GS_ZERO) begin
						add_dig = 1'b1;
						gs_next = GS_INT_MORE;
						take    = 1'b1;
					end else if (c == CH_DOT) begin
						set_frac = 1'b1;
						gs_next  = GS_FRAC_START;
						take     = 1'b1;
					end else if (is_exp_mark(c)) begin
						set_exp = 1'b1;
						gs_next = GS_EXP_START;
						take    = 1'b1;
					end
				end
				GS_FRAC_START: begin
					if (is_digit(c)) begin
						gs_next = GS_FRAC_DIGITS;
						take    = 1'b1;
					end
				end
				GS_FRAC_DIGITS: begin
					if (is_digit(c)) begin
						take = 1'b1;
					end else if (is_exp_mark(c)) begin
						set_exp = 1'b1;
						gs_next = GS_EXP_START;
						take    = 1'b1;
					end
				end
				GS_EXP_START: begin
					if (is_digit(c)) begin
						gs_next = GS_EXP_DIGITS;
						take    = 1'b1;
					end else if (c == CH_PLUS || c == CH_MINUS) begin
						gs_next = GS_EXP_SIGN;
						take    = 1'b1;
					end
				end
				GS_EXP_SIGN, GS_EXP_DIGITS: begin
					if (is_digit(c)) begin
						gs_next = GS_EXP_DIGITS;
						take    = 1'b1;
					end
				end
				default: begin
					gs_next = cur.gs;
				end
			endcase
		end
	end

	// Status: end of buffer, delimiter in an accepting state, or a taken character
	always_comb begin
		accepting = (cur.gs == GS_ZERO) || (cur.gs == GS_INT_FIRST) ||
			(cur.gs == GS_INT_MORE) || (cur.gs == GS_FRAC_DIGITS) ||
			(cur.gs == GS_EXP_DIGITS);
		kind = cur.seen_exponent ? ST_EXP : (cur.seen_fraction ? ST_FRAC : ST_INT);
		priority if (word.at_end) begin
			status = accepting ? kind : ST_ERR;
		end else if (take) begin
			status = ST_BUSY;
		end else if (accepting && is_delim(c)) begin
			status = kind;
		end else begin
			status = ST_ERR;
		end
	end

	// Accumulate one decimal digit: ten times magnitude by shift-add, clamp to the limit
	always_comb begin
		digit   = 4'(c - CH_ZERO);
		mag_ext = PROD_BITS'(cur.magnitude);
		limit   = cur.is_negative ? (PROD_BITS'(1) << (VALUE_BITS - 1))
			: ((PROD_BITS'(1) << (VALUE_BITS - 1)) - PROD_BITS'(1));
		prod    = (mag_ext << 3) + (mag_ext << 1) + PROD_BITS'(digit);
		over    = prod > limit;
	end

	// Assemble the updated state
	always_comb begin
		nxt               = cur;
		nxt.gs            = gs_next;
		nxt.is_negative   = cur.is_negative | set_neg;
		nxt.seen_fraction = cur.seen_fraction | set_frac;
		nxt.seen_exponent = cur.seen_exponent | set_exp;
		if (add_dig) begin
			nxt.magnitude = over ? limit[VALUE_BITS-1:0] : prod[VALUE_BITS-1:0];
			nxt.saturated = cur.saturated | over;
		end
		if (take && cur.char_count != {LENGTH_BITS{1'b1}}) begin
			nxt.char_count = cur.char_count + LENGTH_BITS'(1);
		end
	end

endmodule

// ===== rtl/jnl_checker.sv =====
// Port-level checks of the JSON number lexer and their bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module jnl_props (
	input logic               clk,
	input logic               arst_n,
	input logic               char_valid,
	input logic               char_ready,
	input jnl_pkg::in_word_t  char_word,
	input logic               result_valid,
	input logic               result_ready,
	input jnl_pkg::out_word_t result_word
);
	import jnl_pkg::*;

	// A stalled result word holds
	`ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(result_word), "result word changed while stalled")

	// Every accepted character word yields a result word next cycle
	`ASSERT_NEXT(a_one_result, clk, arst_n, char_valid && char_ready, result_valid, "accepted word gave no result")

	// End of buffer always closes the number
	`ASSERT_NEXT(a_end_closes, clk, arst_n, char_valid && char_ready && char_word.at_end, result_valid && result_word.status != ST_BUSY, "end of buffer left number open")

	// Input stalls only behind a pending result
	`ASSERT_NOW(a_stall_cause, clk, arst_n, !char_ready, result_valid, "input stalled with empty output")

	// Overflow needs consumed digits
	`ASSERT_NOW(a_ovf_len, clk, arst_n, result_valid && result_word.overflow, result_word.consumed_length != 0, "overflow without consumed characters")

endmodule

bind json_number_lexer_top jnl_props u_checker (.*);

// ===== tb/jnl_checker.sv =====
// Checker for the JSON number lexer: predicts each result word and compares it.
`timescale 1ns / 1ps

module jnl_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               char_valid,
	input  logic               char_ready,
	input  jnl_pkg::in_word_t  char_word,
	input  logic               result_valid,
	input  logic               result_ready,
	input  jnl_pkg::out_word_t result_word,
	output int                 fail_count,
	output int                 open_count
);
	import jnl_pkg::*;

	// Lexer state mirrored by the predictor
	gstate_t                lx_state;
	logic [VALUE_BITS-1:0]  lx_mag;
	logic                   lx_neg;
	logic                   lx_sat;
	logic                   lx_frac;
	logic                   lx_exp;
	logic [LENGTH_BITS-1:0] lx_len;

	// Result words predicted but not yet seen on the output channel
	out_word_t pending_lex_results[$];

	task automatic note_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		fail_count++;
	endtask

	function automatic void lex_rearm();
		lx_state = GS_START;
		lx_mag   = '0;
		lx_neg   = 1'b0;
		lx_sat   = 1'b0;
		lx_frac  = 1'b0;
		lx_exp   = 1'b0;
		lx_len   = '0;
	endfunction

	function automatic logic digit_char(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic logic separator_char(input logic [7:0] c);
		case (c)
			CH_SPACE, CH_LF, CH_CR, CH_TAB, CH_COMMA, CH_RBRACK, CH_RBRACE: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic status_t number_kind();
		if (lx_exp)
			return ST_EXP;
		if (lx_frac)
			return ST_FRAC;
		return ST_INT;
	endfunction

	// Fold one decimal digit into the magnitude, clamping at the signed limit
	function automatic void push_digit(input logic [7:0] c);
		logic [63:0] d;
		logic [63:0] lim;
		d   = 64'(c) - 64'(CH_ZERO);
		lim = lx_neg ? (64'd1 << (VALUE_BITS - 1)) : (64'd1 << (VALUE_BITS - 1)) - 64'd1;
		if (64'(lx_mag) > (lim - d) / 64'd10) begin
			lx_mag = VALUE_BITS'(lim);
			lx_sat = 1'b1;
		end else begin
			lx_mag = VALUE_BITS'(64'(lx_mag) * 64'd10 + d);
		end
	endfunction

	// Advance the grammar by one character word and form its result word
	function automatic out_word_t scan_char(input in_word_t w);
		logic [7:0] c;
		status_t    st;
		gstate_t    nxt;
		logic       took;
		out_word_t  r;
		c    = w.character;
		st   = ST_BUSY;
		nxt  = lx_state;
		took = 1'b0;
		if (w.at_end) begin
			case (lx_state)
				GS_ZERO, GS_INT_FIRST, GS_INT_MORE, GS_FRAC_DIGITS, GS_EXP_DIGITS: st = number_kind();
				default: st = ST_ERR;
			endcase
		end else begin
			case (lx_state)
				GS_START, GS_MINUS: begin
					if (c >= CH_ONE && c <= CH_NINE) begin
						push_digit(c);
						nxt  = GS_INT_FIRST;
						took = 1'b1;
					end else if (c == CH_ZERO) begin
						nxt  = GS_ZERO;
						took = 1'b1;
					end else if (c == CH_MINUS && lx_state == GS_START) begin
						lx_neg = 1'b1;
						nxt    = GS_MINUS;
						took   = 1'b1;
					end else begin
						st = ST_ERR;
					end
				end
				GS_ZERO, GS_INT_FIRST, GS_INT_MORE: begin
					if (digit_char(c) && lx_state != GS_ZERO) begin
						push_digit(c);
						nxt  = GS_INT_MORE;
						took = 1'b1;
					end else if (separator_char(c)) begin
						st = number_kind();
					end else if (c == CH_DOT) begin
						lx_frac = 1'b1;
						nxt     = GS_FRAC_START;
						took    = 1'b1;
					end else if (c == CH_EXP_LC || c == CH_EXP_UC) begin
						lx_exp = 1'b1;
						nxt    = GS_EXP_START;
						took   = 1'b1;
					end else begin
						st = ST_ERR;
					end
				end
				GS_FRAC_START: begin
					if (digit_char(c)) begin
						nxt  = GS_FRAC_DIGITS;
						took = 1'b1;
					end else begin
						st = ST_ERR;
					end
				end
				GS_FRAC_DIGITS: begin
					if (digit_char(c)) begin
						took = 1'b1;
					end else if (separator_char(c)) begin
						st = number_kind();
					end else if (c == CH_EXP_LC || c == CH_EXP_UC) begin
						lx_exp = 1'b1;
						nxt    = GS_EXP_START;
						took   = 1'b1;
					end else begin
						st = ST_ERR;
					end
				end
				GS_EXP_START: begin
					if (digit_char(c)) begin
						nxt  = GS_EXP_DIGITS;
						took = 1'b1;
					end else if (c == CH_PLUS || c == CH_MINUS) begin
						nxt  = GS_EXP_SIGN;
						took = 1'b1;
					end else begin
						st = ST_ERR;
					end
				end
				GS_EXP_SIGN: begin
					if (digit_char(c)) begin
						nxt  = GS_EXP_DIGITS;
						took = 1'b1;
					end else begin
						st = ST_ERR;
					end
				end
				GS_EXP_DIGITS: begin
					if (digit_char(c))
						took = 1'b1;
					else if (separator_char(c))
						st = number_kind();
					else
						st = ST_ERR;
				end
				default: st = ST_ERR;
			endcase
		end

		// Count the taken character, holding at all ones
		if (took && lx_len != '1)
			lx_len = lx_len + 1'b1;
		lx_state = nxt;

		r.status          = st;
		r.int_value       = lx_neg ? -lx_mag : lx_mag;
		r.overflow        = lx_sat;
		r.consumed_length = lx_len;

		// Re-arm after a finished or failed number
		if (st != ST_BUSY)
			lex_rearm();
		return r;
	endfunction

	// Compare each taken result word first, then predict the character word taken
	always @(posedge clk or negedge arst_n) begin : watch
		out_word_t want;
		if (!arst_n) begin
			pending_lex_results.delete();
			lex_rearm();
			open_count <= 0;
		end else begin
			if (result_valid && result_ready) begin
				if (pending_lex_results.size() == 0) begin
					note_mismatch("result word with no character word waiting");
				end else begin
					want = pending_lex_results.pop_front();
					if (result_word.status !== want.status)
						note_mismatch($sformatf("status %0d, expected %0d",
							result_word.status, want.status));
					if (result_word.int_value !== want.int_value)
						note_mismatch($sformatf("int_value %0d, expected %0d",
							result_word.int_value, want.int_value));
					if (result_word.overflow !== want.overflow)
						note_mismatch($sformatf("overflow %0b, expected %0b",
							result_word.overflow, want.overflow));
					if (result_word.consumed_length !== want.consumed_length)
						note_mismatch($sformatf("consumed_length %0d, expected %0d",
							result_word.consumed_length, want.consumed_length));
				end
			end
			if (char_valid && char_ready)
				pending_lex_results.push_back(scan_char(char_word));
			open_count <= pending_lex_results.size();
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// Top of the JSON number lexer testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
	import jnl_pkg::*;

	localparam int ITEM_TARGET  = 750;
	localparam int QUIET_TAIL   = 100;
	localparam int CYCLE_LIMIT  = 1000000;

	logic      clk;
	logic      arst_n;
	logic      char_valid;
	logic      char_ready;
	in_word_t  char_word;
	logic      result_valid;
	logic      result_ready;
	out_word_t result_word;

	int fail_count;
	int open_count;
	int chars_sent;
	int cycle_count;
	bit idle_on;

	json_number_lexer_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_valid   (char_valid),
		.char_ready   (char_ready),
		.char_word    (char_word),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_word  (result_word)
	);

	jnl_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_valid   (char_valid),
		.char_ready   (char_ready),
		.char_word    (char_word),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_word  (result_word),
		.fail_count   (fail_count),
		.open_count   (open_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("json_number_lexer_top regression: fail");
			$finish;
		end
	end

	function automatic in_word_t make_word(input logic [7:0] c, input logic e);
		in_word_t w;
		w.character = c;
		w.at_end    = e;
		return w;
	endfunction

	function automatic in_word_t rand_digit();
		return make_word(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
	endfunction

	function automatic logic [7:0] rand_separator();
		case ($urandom_range(0, 6))
			0: return CH_SPACE;
			1: return CH_LF;
			2: return CH_CR;
			3: return CH_TAB;
			4: return CH_COMMA;
			5: return CH_RBRACK;
			default: return CH_RBRACE;
		endcase
	endfunction

	// Present one character word, with an optional gap, and hold it until taken
	task automatic send_word(input in_word_t w);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			char_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		char_valid <= 1'b1;
		char_word  <= w;
		@(posedge clk);
		while (!char_ready)
			@(posedge clk);
		chars_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_word(make_word(s[i], 1'b0));
	endtask

	// Build a well-formed number with random content; optionally corrupt or cut it
	task automatic send_number(input bit broken);
		in_word_t seq[$];
		int       cut;
		if ($urandom_range(0, 2) == 0)
			seq.push_back(make_word(CH_MINUS, 1'b0));
		if ($urandom_range(0, 4) == 0) begin
			seq.push_back(make_word(CH_ZERO, 1'b0));
		end else begin
			seq.push_back(make_word(8'(CH_ONE + $urandom_range(0, 8)), 1'b0));
			repeat (($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(0, 5))
				seq.push_back(rand_digit());
		end
		if ($urandom_range(0, 1)) begin
			seq.push_back(make_word(CH_DOT, 1'b0));
			repeat ($urandom_range(1, 4))
				seq.push_back(rand_digit());
		end
		if ($urandom_range(0, 2) == 0) begin
			seq.push_back(make_word($urandom_range(0, 1) ? CH_EXP_LC : CH_EXP_UC, 1'b0));
			case ($urandom_range(0, 2))
				1: seq.push_back(make_word(CH_PLUS, 1'b0));
				2: seq.push_back(make_word(CH_MINUS, 1'b0));
				default: ;
			endcase
			repeat ($urandom_range(1, 3))
				seq.push_back(rand_digit());
		end
		if ($urandom_range(0, 3) == 0)
			seq.push_back(make_word(8'($urandom), 1'b1));
		else
			seq.push_back(make_word(rand_separator(), 1'b0));

		if (broken) begin
			cut = $urandom_range(0, seq.size() - 1);
			if ($urandom_range(0, 1)) begin
				seq[cut] = make_word(8'($urandom), 1'b0);
			end else begin
				while (seq.size() > cut)
					void'(seq.pop_back());
				seq.push_back(make_word(8'($urandom), 1'b1));
			end
		end
		foreach (seq[i])
			send_word(seq[i]);
	endtask

	// Result side: ready in random runs, with stall bursts while idling is on
	initial begin
		result_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			result_ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			if (idle_on) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
		end
	end

	initial begin
		chars_sent  = 0;
		idle_on     = 1'b1;
		arst_n     <= 1'b0;
		char_valid <= 1'b0;
		char_word  <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty buffer, bytes at both ends of the range, leading zero
		// followed by a digit, negative zero, exponent closed by end of buffer,
		// and a negative integer part that clamps
		send_word(make_word(8'h00, 1'b1));
		send_word(make_word(8'hFF, 1'b0));
		send_text(",");
		send_text("01");
		send_text("-0\t");
		send_text("9.5e+3");
		send_word(make_word(8'hA5, 1'b1));
		send_text("-9999999999}");

		// Random numbers, broken numbers and noise
		while (chars_sent < ITEM_TARGET) begin
			if (chars_sent >= ITEM_TARGET - QUIET_TAIL)
				idle_on = 1'b0;
			else if ($urandom_range(0, 11) == 0)
				idle_on = !idle_on;
			case ($urandom_range(0, 19)) inside
				[0:13]:  send_number(1'b0);
				[14:16]: send_number(1'b1);
				default: repeat ($urandom_range(1, 4))
					send_word(make_word(8'($urandom), $urandom_range(0, 5) == 0));
			endcase
		end
		char_valid <= 1'b0;

		// Drain, then allow for the output register
		while (open_count != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("json_number_lexer_top regression: pass");
		else
			$display("json_number_lexer_top regression: fail");
		$finish;
	end

endmodule
